// File: rtl/core/cspal_pkg.sv
// Package for the character sequence reverser with palindrome check.
// Holds the store size, counter widths, the queue command and result types.
// Used by every module of the block but cspal_ram; depends on nothing else.
package cspal_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHAR_W      = 8;
    localparam int OUT_CNT_W   = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0]  FILL_MAX = CNT_W'(CAPACITY);
    localparam logic [QCNT_W-1:0] Q_FULL   = QCNT_W'(QUEUE_DEPTH);
    localparam logic [CHAR_W-1:0] ASCII_UC_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UC_Z = 8'h5A;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              append;
        logic              close;
    } t_cmd;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] seq_length;
        logic [OUT_CNT_W-1:0] upper_count;
        logic                 is_palindrome;
        logic                 is_final;
        logic                 char_valid;
        logic [CHAR_W-1:0]    out_char;
    } t_result;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= ASCII_UC_A) && (c <= ASCII_UC_Z);
    endfunction

endpackage

// File: rtl/core/cspal_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
// Used for the character store of the reverser.
module cspal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/core/cspal_front.sv
// Front end of the reverser: accepts input requests, drops empty ones
// and queues append and close commands for the back end.
// Depends on cspal_pkg.
module cspal_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [cspal_pkg::CHAR_W-1:0] i_char,
    input  logic                         i_present,
    input  logic                         i_end,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output cspal_pkg::t_cmd              o_cmd
);
    import cspal_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign o_ready     = (r_count != Q_FULL);
    assign push        = i_valid && o_ready && (i_present || i_end);
    assign o_cmd_valid = (r_count != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{ch: i_char, append: i_present, close: i_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/cspal_back.sv
// Back end of the reverser: writes bytes into the store, keeps the counts
// and walks the store backward on close, checking the palindrome as it goes.
// Depends on cspal_pkg and cspal_ram.
module cspal_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  cspal_pkg::t_cmd    i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output cspal_pkg::t_result o_result
);
    import cspal_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [CNT_W-1:0]  r_upper;
    logic [CNT_W-1:0]  n_upper;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  n_len;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  n_k;
    logic              r_dvalid;
    logic              n_dvalid;
    logic              r_match;
    logic              n_match;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;

    logic              we;
    logic [CHAR_W-1:0] rd_fwd;
    logic [CHAR_W-1:0] rd_rev;
    logic              out_free;
    logic              is_last;
    logic              load;
    logic              same;

    assign out_free = !r_out_valid || i_ready;
    assign is_last  = (r_len == '0) || (r_k == r_len - CNT_W'(1));
    assign load     = (r_state == ST_EMIT) && r_dvalid && out_free;
    assign same     = (rd_fwd == rd_rev);
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign we = (r_state == ST_IDLE) && i_cmd_valid && i_cmd.append && (r_fill != FILL_MAX);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_upper  = r_upper;
        n_len    = r_len;
        n_k      = r_k;
        n_match  = r_match;
        n_result = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (we) begin
                        n_fill = r_fill + CNT_W'(1);
                        if (is_upper(i_cmd.ch)) begin
                            n_upper = r_upper + CNT_W'(1);
                        end
                    end
                    if (i_cmd.close) begin
                        n_state = ST_EMIT;
                        n_len   = n_fill;
                        n_k     = '0;
                        n_match = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (load) begin
                    n_k     = r_k + CNT_W'(1);
                    n_match = r_match && same;
                    n_result.out_char      = (r_len == '0) ? '0 : rd_rev;
                    n_result.char_valid    = (r_len != '0);
                    n_result.is_final      = is_last;
                    n_result.is_palindrome = is_last && ((r_len == '0) || (r_match && same));
                    n_result.upper_count   = is_last ? OUT_CNT_W'(r_upper) : '0;
                    n_result.seq_length    = is_last ? OUT_CNT_W'(r_len) : '0;
                    if (is_last) begin
                        n_state = ST_IDLE;
                        n_fill  = '0;
                        n_upper = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_dvalid = (r_state == ST_EMIT) && (n_state == ST_EMIT);

    cspal_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (r_fill[ADDR_W-1:0]),
        .i_wdata  (i_cmd.ch),
        .i_raddr_a(n_k[ADDR_W-1:0]),
        .i_raddr_b(ADDR_W'(n_len - CNT_W'(1) - n_k)),
        .o_rdata_a(rd_fwd),
        .o_rdata_b(rd_rev)
    );

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_k      <= n_k;
        r_match  <= n_match;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_upper     <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_upper  <= n_upper;
            r_dvalid <= n_dvalid;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// File: rtl/core/char_sequence_reverse_palindrome.sv
// Top level of the character sequence reverser with palindrome check.
// Joins the front end queue and the back end store walker.
// Depends on cspal_pkg, cspal_front, cspal_back and cspal_ram.
//
//   Group   Dir  tdata                                   tuser         tlast
//   s_axis  in   in_char[7:0]                            char_present  end_of_sequence
//   m_axis  out  out_char[7:0] is_palindrome[8]          char_valid    is_final
//                upper_count[15:9] seq_length[22:16]
//
// Requests are taken while the queue has room; a four-entry queue buffers requests
// while the back end is emitting. A run is emitted one result per cycle while
// the output does not stall; an empty run gives a single result.
// Reset is synchronous and active low; the store holds no reset value.
// Output stalls hold the result register and pause the store walk.
module char_sequence_reverse_palindrome (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_char[7:0]
    input  logic        s_axis_tuser,   // char_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_char, is_palindrome, upper_count, seq_length
    output logic        m_axis_tuser,   // char_valid
    output logic        m_axis_tlast
);
    import cspal_pkg::*;

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_ready;
    t_result result;

    cspal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_char     (s_axis_tdata),
        .i_present  (s_axis_tuser),
        .i_end      (s_axis_tlast),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready),
        .o_cmd      (cmd)
    );

    cspal_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {1'b0, result.seq_length, result.upper_count,
                           result.is_palindrome, result.out_char};
    assign m_axis_tuser = result.char_valid;
    assign m_axis_tlast = result.is_final;

    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[22:16] == 7'd0))
        else $error("result without a byte must be the final one of an empty run");

    a_stats_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[22:8] == 15'd0))
        else $error("summary fields set on a non-final result");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[22:16] <= 7'(CAPACITY)) &&
            (m_axis_tdata[15:9] <= m_axis_tdata[22:16]))
        else $error("final length or upper-case count out of range");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

// File: tb/sv/char_sequence_reverse_palindrome_tb.sv
// Self-checking testbench for char_sequence_reverse_palindrome: a directed table,
// then random byte runs (palindromes, near-palindromes, overflowing runs, noise).
// Depends on cspal_pkg and the block's RTL; results are checked against a predictor.
module char_sequence_reverse_palindrome_tb;
    import cspal_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       append;
        logic       close;
        logic       typed;
        t_result    res;
    } t_row;

    localparam t_result NO_RESULT = '0;
    localparam int      DIR_ROWS  = 22;
    localparam int      RANDOM_REQUESTS = 390;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // in_char[7:0]
    logic        s_axis_tuser;   // char_present
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_char, is_palindrome, upper_count, seq_length
    logic        m_axis_tuser;   // char_valid
    logic        m_axis_tlast;

    t_row       directed_rows [DIR_ROWS];
    t_row       request_q [$];
    t_result    expected_reversal [$];
    logic [7:0] shadow_chars [CAPACITY];
    int         shadow_fill;
    int         shadow_uppers;
    bit         shadow_dropped;
    int         error_count;
    int         request_count;
    int         result_count;
    int         run_count;
    int         palindrome_runs;
    int         overflow_runs;

    char_sequence_reverse_palindrome uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_result sole_result(logic [7:0] ch, logic valid, logic pal,
                                            logic [6:0] uppers, logic [6:0] len);
        t_result r;
        r = NO_RESULT;
        r.out_char      = ch;
        r.char_valid    = valid;
        r.is_final      = 1'b1;
        r.is_palindrome = pal;
        r.upper_count   = uppers;
        r.seq_length    = len;
        return r;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0, 1: begin
                return 8'h41 + 8'($urandom_range(0, 25));
            end
            2: begin
                return 8'h61 + 8'($urandom_range(0, 25));
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // Mirrors the block: append first, then on close emit the store last byte first.
    task automatic predict_reversal(logic [7:0] ch, logic append, logic close);
        t_result r;
        bit      pal;
        int      k;
        if (append) begin
            if (shadow_fill < CAPACITY) begin
                shadow_chars[shadow_fill] = ch;
                shadow_fill++;
                if (ch >= 8'h41 && ch <= 8'h5A) shadow_uppers++;
            end else begin
                shadow_dropped = 1'b1;
            end
        end
        if (close) begin
            pal = 1'b1;
            for (k = 0; k < shadow_fill / 2; k++) begin
                if (shadow_chars[k] != shadow_chars[shadow_fill - 1 - k]) pal = 1'b0;
            end
            if (shadow_fill == 0) begin
                expected_reversal.insert(expected_reversal.size(),
                                         sole_result(8'h00, 1'b0, 1'b1, 7'd0, 7'd0));
            end
            for (k = 0; k < shadow_fill; k++) begin
                r = NO_RESULT;
                r.out_char   = shadow_chars[shadow_fill - 1 - k];
                r.char_valid = 1'b1;
                if (k == shadow_fill - 1) begin
                    r.is_final      = 1'b1;
                    r.is_palindrome = pal;
                    r.upper_count   = 7'(shadow_uppers);
                    r.seq_length    = 7'(shadow_fill);
                end
                expected_reversal.insert(expected_reversal.size(), r);
            end
            run_count++;
            if (pal) palindrome_runs++;
            if (shadow_dropped) overflow_runs++;
            shadow_fill    = 0;
            shadow_uppers  = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // Mostly well-formed runs with random content, some near-palindromes,
    // a few that overflow the store, and stray requests that do nothing.
    task automatic build_random_runs(int target);
        int         taken;
        int         len;
        int         mode;
        int         k;
        bit         close_with_last;
        logic [7:0] seq [$];
        taken = 0;
        while (taken < target) begin
            seq.delete();
            mode = $urandom_range(0, 19);
            if (mode == 0) len = $urandom_range(CAPACITY, CAPACITY + 8);
            else if (mode < 4) len = $urandom_range(9, 24);
            else len = $urandom_range(0, 8);
            for (k = 0; k < len; k++) seq.insert(seq.size(), pick_char());
            if ($urandom_range(0, 1)) begin
                for (k = 0; k < len / 2; k++) seq[len - 1 - k] = seq[k];
            end
            if (len > 1 && $urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, len - 1);
                seq[k] = seq[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            close_with_last = (len > 0) && ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    request_q.insert(request_q.size(),
                                     t_row'{8'($urandom), 1'b0, 1'b0, 1'b0, NO_RESULT});
                    taken++;
                end
                request_q.insert(request_q.size(),
                                 t_row'{seq[k], 1'b1, close_with_last && (k == len - 1),
                                        1'b0, NO_RESULT});
                taken++;
            end
            if (!close_with_last) begin
                request_q.insert(request_q.size(),
                                 t_row'{8'($urandom), 1'b0, 1'b1, 1'b0, NO_RESULT});
                taken++;
            end
        end
    endtask

    task automatic send_request(t_row row, bit no_idle);
        int gap;
        int before_count;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.ch;
        s_axis_tuser  <= row.append;
        s_axis_tlast  <= row.close;
        do @(posedge i_clk); while (!s_axis_tready);
        request_count++;
        before_count = expected_reversal.size();
        predict_reversal(row.ch, row.append, row.close);
        if (row.typed) begin
            while (expected_reversal.size() > before_count) void'(expected_reversal.pop_back());
            expected_reversal.insert(expected_reversal.size(), row.res);
        end
        @(negedge i_clk);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (expected_reversal.size() == 0) begin
                $error("result with out_char %0d arrived with nothing expected",
                       m_axis_tdata[7:0]);
                error_count++;
            end else begin
                want = expected_reversal.pop_front();
                check_field("out_char", want.out_char, m_axis_tdata[7:0]);
                check_field("char_valid", want.char_valid, m_axis_tuser);
                check_field("is_final", want.is_final, m_axis_tlast);
                check_field("is_palindrome", want.is_palindrome, m_axis_tdata[8]);
                check_field("upper_count", want.upper_count, m_axis_tdata[15:9]);
                check_field("seq_length", want.seq_length, m_axis_tdata[22:16]);
            end
        end
    end

    initial begin
        int gap;
        bit no_idle;
        m_axis_tready = 1'b0;
        no_idle = 1'b0;
        do @(negedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
            gap = no_idle ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        bit no_idle;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tuser   = 1'b0;
        s_axis_tlast   = 1'b0;
        shadow_fill    = 0;
        shadow_uppers  = 0;
        shadow_dropped = 1'b0;
        error_count    = 0;
        no_idle        = 1'b0;

        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, sole_result(8'h00, 1'b0, 1'b1, 7'd0, 7'd0)},
            '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
            '{8'h41, 1'b1, 1'b1, 1'b1, sole_result(8'h41, 1'b1, 1'b1, 7'd1, 7'd1)},
            '{8'h5A, 1'b1, 1'b1, 1'b1, sole_result(8'h5A, 1'b1, 1'b1, 7'd1, 7'd1)},
            '{8'h40, 1'b1, 1'b1, 1'b1, sole_result(8'h40, 1'b1, 1'b1, 7'd0, 7'd1)},
            '{8'h5B, 1'b1, 1'b1, 1'b1, sole_result(8'h5B, 1'b1, 1'b1, 7'd0, 7'd1)},
            '{8'hC1, 1'b1, 1'b1, 1'b1, sole_result(8'hC1, 1'b1, 1'b1, 7'd0, 7'd1)},
            '{8'h00, 1'b1, 1'b1, 1'b1, sole_result(8'h00, 1'b1, 1'b1, 7'd0, 7'd1)},
            '{8'hFF, 1'b1, 1'b1, 1'b1, sole_result(8'hFF, 1'b1, 1'b1, 7'd0, 7'd1)},
            '{8'h61, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'h42, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'h61, 1'b1, 1'b1, 1'b0, NO_RESULT},
            '{8'h41, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'h42, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'h55, 1'b0, 1'b1, 1'b0, NO_RESULT},
            '{8'h7F, 1'b0, 1'b1, 1'b1, sole_result(8'h00, 1'b0, 1'b1, 7'd0, 7'd0)},
            '{8'h78, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'h78, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'hAA, 1'b0, 1'b0, 1'b0, NO_RESULT},
            '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
            '{8'h80, 1'b1, 1'b0, 1'b0, NO_RESULT},
            '{8'h7F, 1'b1, 1'b1, 1'b0, NO_RESULT}
        };
        foreach (directed_rows[i]) request_q.insert(request_q.size(), directed_rows[i]);
        build_random_runs(RANDOM_REQUESTS);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (request_q.size() > 0) begin
            if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
            send_request(request_q.pop_front(), no_idle);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_reversal.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests forming %0d runs; checked %0d results.",
                 request_count, run_count, result_count);
        $display("Runs read the same both ways: %0d; runs that overflowed the store: %0d.",
                 palindrome_runs, overflow_runs);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
